/* sv/ppp_pkg.sv */
`timescale 1ns / 1ps
package ppp_pkg;

    localparam int CoordW  = 32;
    localparam int CompW   = 16;
    localparam int NumW    = 51;
    localparam int NumMagW = 48;
    localparam int DenW    = 34;
    localparam int DenMagW = 32;
    localparam int ProdW   = 63;
    localparam int QuoW    = 41;
    localparam int HeadW   = ProdW - QuoW;
    localparam int SumW    = 43;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;

    typedef enum logic [2:0] {
        REG_NORMAL_X     = 3'd0,
        REG_NORMAL_Y     = 3'd1,
        REG_NORMAL_Z     = 3'd2,
        REG_PLANE_OFFSET = 3'd3,
        REG_DIR_X        = 3'd4,
        REG_DIR_Y        = 3'd5,
        REG_DIR_Z        = 3'd6,
        REG_ALONG_NORMAL = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CompW-1:0]  normal_x;
        logic signed [CompW-1:0]  normal_y;
        logic signed [CompW-1:0]  normal_z;
        logic signed [CoordW-1:0] plane_offset;
        logic signed [CompW-1:0]  dir_x;
        logic signed [CompW-1:0]  dir_y;
        logic signed [CompW-1:0]  dir_z;
        logic                     along_normal;
    } cfg_t;

    // one division lane: partial remainder, dividend bits still to shift in
    typedef struct packed {
        logic [DenMagW-1:0] rem;
        logic [QuoW-1:0]    dvd;
        logic [QuoW-1:0]    quo;
        logic               ovf;
    } lane_t;

    typedef struct packed {
        logic                          valid;
        logic                          par;
        logic [2:0]                    neg;
        logic [DenMagW-1:0]            den;
        logic [2:0][CoordW-1:0]        pt;
        lane_t [2:0]                   lane;
    } stage_t;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
        logic              par;
        logic              sat;
    } res_t;

endpackage

/* sv/ppp_in_if.sv */
`timescale 1ns / 1ps
interface ppp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

/* sv/ppp_out_if.sv */
`timescale 1ns / 1ps
interface ppp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               parallel_flag;
    logic               saturated_flag;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output parallel_flag, output saturated_flag, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input parallel_flag, input saturated_flag, output ready);
endinterface

/* sv/ppp_cfg.sv */
`timescale 1ns / 1ps
module ppp_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ppp_pkg::AddrW-1:0] paddr,
    input  logic [ppp_pkg::DataW-1:0] pwdata,
    output logic [ppp_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output ppp_pkg::cfg_t             cfg
);
    import ppp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{normal_x: '0, normal_y: '0, normal_z: 16'sd16384,
                         plane_offset: '0, dir_x: '0, dir_y: '0,
                         dir_z: 16'sd16384, along_normal: 1'b0};
        end
        else if (wr)
        begin
            unique case (idx)
                REG_NORMAL_X:     cfg_reg.normal_x     <= pwdata[CompW-1:0];
                REG_NORMAL_Y:     cfg_reg.normal_y     <= pwdata[CompW-1:0];
                REG_NORMAL_Z:     cfg_reg.normal_z     <= pwdata[CompW-1:0];
                REG_PLANE_OFFSET: cfg_reg.plane_offset <= pwdata[CoordW-1:0];
                REG_DIR_X:        cfg_reg.dir_x        <= pwdata[CompW-1:0];
                REG_DIR_Y:        cfg_reg.dir_y        <= pwdata[CompW-1:0];
                REG_DIR_Z:        cfg_reg.dir_z        <= pwdata[CompW-1:0];
                REG_ALONG_NORMAL: cfg_reg.along_normal <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_NORMAL_X:     prdata = DataW'(unsigned'(cfg_reg.normal_x));
            REG_NORMAL_Y:     prdata = DataW'(unsigned'(cfg_reg.normal_y));
            REG_NORMAL_Z:     prdata = DataW'(unsigned'(cfg_reg.normal_z));
            REG_PLANE_OFFSET: prdata = DataW'(unsigned'(cfg_reg.plane_offset));
            REG_DIR_X:        prdata = DataW'(unsigned'(cfg_reg.dir_x));
            REG_DIR_Y:        prdata = DataW'(unsigned'(cfg_reg.dir_y));
            REG_DIR_Z:        prdata = DataW'(unsigned'(cfg_reg.dir_z));
            REG_ALONG_NORMAL: prdata = DataW'(cfg_reg.along_normal);
            default:          prdata = '0;
        endcase
    end
endmodule

/* sv/ppp_div_cell.sv */
`timescale 1ns / 1ps
module ppp_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ppp_pkg::stage_t d,
    output ppp_pkg::stage_t q
);
    import ppp_pkg::*;

    stage_t q_reg;
    stage_t q_next;
    logic [DenMagW:0] trial [3];
    logic [DenMagW:0] diff  [3];
    logic             ge    [3];

    // one restoring quotient bit per lane: shift in, compare, subtract
    always_comb
    begin
        q_next = d;
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {d.lane[i].rem, d.lane[i].dvd[QuoW-1]};
            diff[i]  = trial[i] - {1'b0, d.den};
            ge[i]    = trial[i] >= {1'b0, d.den};
            q_next.lane[i].rem = ge[i] ? diff[i][DenMagW-1:0] : trial[i][DenMagW-1:0];
            q_next.lane[i].dvd = {d.lane[i].dvd[QuoW-2:0], 1'b0};
            q_next.lane[i].quo = {d.lane[i].quo[QuoW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

/* sv/point_plane_projection_top.sv */
`timescale 1ns / 1ps
// Point-onto-plane projection, one Q16.16 point per word.
//
// in_w   : sink of x_in/y_in/z_in words, taken when valid and ready are high.
// out_w  : source of x_out/y_out/z_out plus parallel_flag and saturated_flag.
// APB    : eight registers at byte address 4*i (normal, offset, direction,
//          along_normal). Write them only while no word is in flight.
//
// From input acceptance to output valid a word passes through four front
// stages (products, dot sums, dividend product, divider setup), a chain of
// 41 divider cells that each settle one quotient bit for all three axes,
// and the output register. Throughput is one word per cycle while the skid
// register is empty.
//
// A stalled receiver is absorbed by a one-word skid register behind the
// output register; while it holds a word the whole pipeline freezes and
// in_w.ready drops. Reset empties every stage and loads the register
// defaults (normal and direction along +z, zero offset).
module point_plane_projection_top (
    input  logic                      clk,
    input  logic                      rst_n,
    ppp_in_if.sink                    in_w,
    ppp_out_if.source                 out_w,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ppp_pkg::AddrW-1:0] paddr,
    input  logic [ppp_pkg::DataW-1:0] pwdata,
    output logic [ppp_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import ppp_pkg::*;

    localparam logic [QuoW-1:0] CapQ = QuoW'(1) << (QuoW - 1);

    cfg_t cfg;
    logic en;

    // output register with one-word skid
    res_t out_reg;
    res_t skid_reg;
    logic out_v_reg;
    logic skid_v_reg;

    ppp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1: all six products
    logic                     s1_valid_reg;
    logic signed [CoordW-1:0] s1_pt_reg [3];
    logic signed [47:0]       s1_nx_reg [3];
    logic signed [31:0]       s1_nd_reg [3];
    logic signed [CompW-1:0]  s1_d_reg  [3];
    logic signed [CompW-1:0]  nrm [3];
    logic signed [CompW-1:0]  dsel [3];
    logic signed [CoordW-1:0] pin [3];

    assign nrm[0] = cfg.normal_x;
    assign nrm[1] = cfg.normal_y;
    assign nrm[2] = cfg.normal_z;
    assign dsel[0] = cfg.along_normal ? cfg.normal_x : cfg.dir_x;
    assign dsel[1] = cfg.along_normal ? cfg.normal_y : cfg.dir_y;
    assign dsel[2] = cfg.along_normal ? cfg.normal_z : cfg.dir_z;
    assign pin[0] = in_w.x_in;
    assign pin[1] = in_w.y_in;
    assign pin[2] = in_w.z_in;

    assign en         = ~skid_v_reg;
    assign in_w.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_w.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_pt_reg[i] <= pin[i];
                s1_nx_reg[i] <= 48'(nrm[i] * pin[i]);
                s1_nd_reg[i] <= 32'(nrm[i] * dsel[i]);
                s1_d_reg[i]  <= dsel[i];
            end
        end
    end

    // stage 2: dot sums, magnitudes and signs
    logic                     s2_valid_reg;
    logic [CoordW-1:0]        s2_pt_reg [3];
    logic [NumMagW-1:0]       s2_nmag_reg;
    logic [DenMagW-1:0]       s2_dmag_reg;
    logic [CompW-1:0]         s2_cmag_reg [3];
    logic [2:0]               s2_neg_reg;
    logic                     s2_par_reg;
    logic signed [NumW-1:0]   num;
    logic signed [DenW-1:0]   den;
    logic [NumW-1:0]          num_abs;
    logic [DenW-1:0]          den_abs;
    logic [CompW:0]           cmp_abs [3];

    always_comb
    begin
        num = {{(NumW-CoordW-14){cfg.plane_offset[CoordW-1]}}, cfg.plane_offset, 14'b0}
            - NumW'(s1_nx_reg[0]) - NumW'(s1_nx_reg[1]) - NumW'(s1_nx_reg[2]);
        den = DenW'(s1_nd_reg[0]) + DenW'(s1_nd_reg[1]) + DenW'(s1_nd_reg[2]);
        num_abs = num[NumW-1] ? NumW'(-num) : NumW'(num);
        den_abs = den[DenW-1] ? DenW'(-den) : DenW'(den);
        for (int i = 0; i < 3; i++)
            cmp_abs[i] = s1_d_reg[i][CompW-1] ? (CompW+1)'(-s1_d_reg[i])
                                              : (CompW+1)'(s1_d_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_nmag_reg <= num_abs[NumMagW-1:0];
            s2_dmag_reg <= den_abs[DenMagW-1:0];
            s2_par_reg  <= (den == '0);
            for (int i = 0; i < 3; i++)
            begin
                s2_pt_reg[i]   <= s1_pt_reg[i];
                s2_cmag_reg[i] <= cmp_abs[i][CompW-1:0] | {cmp_abs[i][CompW], {(CompW-1){1'b0}}};
                s2_neg_reg[i]  <= num[NumW-1] ^ s1_d_reg[i][CompW-1] ^ den[DenW-1];
            end
        end
    end

    // stage 3: dividend products
    logic                     s3_valid_reg;
    logic [CoordW-1:0]        s3_pt_reg [3];
    logic [ProdW-1:0]         s3_prod_reg [3];
    logic [DenMagW-1:0]       s3_dmag_reg;
    logic [2:0]               s3_neg_reg;
    logic                     s3_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dmag_reg <= s2_dmag_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_par_reg  <= s2_par_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_pt_reg[i]   <= s2_pt_reg[i];
                s3_prod_reg[i] <= ProdW'(s2_nmag_reg * s2_cmag_reg[i]);
            end
        end
    end

    // stage 4: divider setup; quotient above the 41 low bits means capped
    stage_t chain [QuoW+1];
    stage_t s4_next;

    always_comb
    begin
        s4_next.valid = s3_valid_reg;
        s4_next.par   = s3_par_reg;
        s4_next.neg   = s3_neg_reg;
        s4_next.den   = s3_dmag_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_next.pt[i]       = s3_pt_reg[i];
            s4_next.lane[i].rem = DenMagW'(s3_prod_reg[i][ProdW-1:QuoW]);
            s4_next.lane[i].ovf = {{(DenMagW-HeadW){1'b0}}, s3_prod_reg[i][ProdW-1:QuoW]}
                                  >= s3_dmag_reg;
            s4_next.lane[i].dvd = s3_prod_reg[i][QuoW-1:0];
            s4_next.lane[i].quo = '0;
        end
    end

    stage_t s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_reg <= '0;
        else if (en)
            s4_reg <= s4_next;
    end

    assign chain[0] = s4_reg;

    for (genvar k = 0; k < QuoW; k++)
    begin : g_cell
        ppp_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (chain[k]),
            .q     (chain[k+1])
        );
    end

    // finish: cap, apply sign, add and clamp; a parallel word keeps its point
    stage_t             last;
    res_t               fin;
    logic [QuoW-1:0]    qmag;
    logic signed [SumW-1:0] sum;
    logic [CoordW-1:0]  clamped [3];
    logic [2:0]         clip;

    assign last = chain[QuoW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qmag = (last.lane[i].ovf || last.lane[i].quo > CapQ) ? CapQ : last.lane[i].quo;
            sum  = SumW'(signed'(last.pt[i]))
                 + (last.neg[i] ? -SumW'(qmag) : SumW'(qmag));
            if (sum > SumW'(32'sh7fff_ffff))
            begin
                clamped[i] = 32'h7fff_ffff;
                clip[i]    = 1'b1;
            end
            else if (sum < -SumW'(33'sh0_8000_0000))
            begin
                clamped[i] = 32'h8000_0000;
                clip[i]    = 1'b1;
            end
            else
            begin
                clamped[i] = sum[CoordW-1:0];
                clip[i]    = 1'b0;
            end
        end
        fin.par = last.par;
        fin.x   = last.par ? last.pt[0] : clamped[0];
        fin.y   = last.par ? last.pt[1] : clamped[1];
        fin.z   = last.par ? last.pt[2] : clamped[2];
        fin.sat = ~last.par & (|clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_w.ready)
                skid_v_reg <= 1'b0;
        end
        else if (last.valid)
        begin
            if (out_v_reg && !out_w.ready)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
        else if (out_w.ready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_w.ready)
                out_reg <= skid_reg;
        end
        else if (last.valid)
        begin
            if (out_v_reg && !out_w.ready)
                skid_reg <= fin;
            else
                out_reg <= fin;
        end
    end

    assign out_w.valid          = out_v_reg;
    assign out_w.x_out          = out_reg.x;
    assign out_w.y_out          = out_reg.y;
    assign out_w.z_out          = out_reg.z;
    assign out_w.parallel_flag  = out_reg.par;
    assign out_w.saturated_flag = out_reg.sat;

    // a passed-through point is never marked clamped
    a_par_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_w.valid && out_w.parallel_flag |-> !out_w.saturated_flag)
        else $error("parallel word flagged saturated");

    // a clamped word carries at least one rail value
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_w.valid && out_w.saturated_flag |->
            out_w.x_out == 32'sh7fff_ffff || out_w.x_out == -32'sh8000_0000 ||
            out_w.y_out == 32'sh7fff_ffff || out_w.y_out == -32'sh8000_0000 ||
            out_w.z_out == 32'sh7fff_ffff || out_w.z_out == -32'sh8000_0000)
        else $error("saturated word without rail value");

    // input stalls only while a word sits in the output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_w.ready |-> out_w.valid)
        else $error("input stalled with empty output");

    // skid fills only when the receiver held off a valid word
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_w.valid && !out_w.ready))
        else $error("skid filled without stall");
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import ppp_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    localparam longint unsigned DeltaCap = 64'd1 << 40;
    localparam int DrainCycles = 60;
    localparam int StallLimit  = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic pready;

    ppp_in_if  in_w ();
    ppp_out_if out_w ();

    point_t points_pending[$];
    res_t   projections_due[$];
    cfg_t   plane;
    bit     calm = 1'b0;
    int     errors = 0;
    int     quiet_cycles = 0;

    point_plane_projection_top dut (
        .clk(clk), .rst_n(rst_n), .in_w(in_w.sink), .out_w(out_w.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Move the point along the chosen direction until it sits on the plane.
    function automatic res_t plane_hit(input point_t pt);
        longint p[3];
        longint d[3];
        longint num, den, s, dl;
        longint unsigned q;
        logic neg;
        res_t r;
        p[0] = pt.x;
        p[1] = pt.y;
        p[2] = pt.z;
        if (plane.along_normal) begin
            d[0] = $signed(plane.normal_x);
            d[1] = $signed(plane.normal_y);
            d[2] = $signed(plane.normal_z);
        end
        else begin
            d[0] = $signed(plane.dir_x);
            d[1] = $signed(plane.dir_y);
            d[2] = $signed(plane.dir_z);
        end
        num = longint'($signed(plane.plane_offset)) * 16384
            - (longint'($signed(plane.normal_x)) * p[0]
               + longint'($signed(plane.normal_y)) * p[1]
               + longint'($signed(plane.normal_z)) * p[2]);
        den = longint'($signed(plane.normal_x)) * d[0]
            + longint'($signed(plane.normal_y)) * d[1]
            + longint'($signed(plane.normal_z)) * d[2];
        r.par = (den == 0);
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s = p[i];
            if (den != 0) begin
                q = (magnitude(num) * magnitude(d[i])) / magnitude(den);
                if (q > DeltaCap) q = DeltaCap;
                neg = (num < 0) ^ (d[i] < 0) ^ (den < 0);
                dl = neg ? -longint'(q) : longint'(q);
                s = p[i] + dl;
                if (s > 64'sd2147483647) begin
                    s = 64'sd2147483647;
                    r.sat = 1'b1;
                end
                else if (s < -64'sd2147483648) begin
                    s = -64'sd2147483648;
                    r.sat = 1'b1;
                end
            end
            if (i == 0) r.x = s[31:0];
            else if (i == 1) r.y = s[31:0];
            else r.z = s[31:0];
        end
        return r;
    endfunction

    // Driver: hold a word until taken, then load the next one or idle.
    always @(posedge clk) begin
        point_t nxt;
        logic nv;
        if (rst_n) begin
            nv = in_w.valid;
            if (in_w.valid && in_w.ready) begin
                nxt.x = in_w.x_in;
                nxt.y = in_w.y_in;
                nxt.z = in_w.z_in;
                projections_due.insert(projections_due.size(), plane_hit(nxt));
                nv = 1'b0;
            end
            if (!nv && points_pending.size() > 0
                && (calm || $urandom_range(0, 99) >= 22)) begin
                nxt = points_pending.pop_front();
                in_w.x_in <= nxt.x;
                in_w.y_in <= nxt.y;
                in_w.z_in <= nxt.z;
                nv = 1'b1;
            end
            in_w.valid <= nv;
            out_w.ready <= calm || $urandom_range(0, 99) >= 22;
        end
        else begin
            in_w.valid <= 1'b0;
            in_w.x_in <= '0;
            in_w.y_in <= '0;
            in_w.z_in <= '0;
            out_w.ready <= 1'b0;
        end
    end

    // Monitor: compare each result word with the oldest projection due.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && out_w.valid && out_w.ready) begin
            if (projections_due.size() == 0) begin
                $error("unexpected result word x=%0d", out_w.x_out);
                errors++;
            end
            else begin
                want = projections_due.pop_front();
                if (out_w.x_out !== want.x) begin
                    $error("x_out expected %0d actual %0d", $signed(want.x), out_w.x_out);
                    errors++;
                end
                if (out_w.y_out !== want.y) begin
                    $error("y_out expected %0d actual %0d", $signed(want.y), out_w.y_out);
                    errors++;
                end
                if (out_w.z_out !== want.z) begin
                    $error("z_out expected %0d actual %0d", $signed(want.z), out_w.z_out);
                    errors++;
                end
                if (out_w.parallel_flag !== want.par) begin
                    $error("parallel_flag expected %0b actual %0b",
                           want.par, out_w.parallel_flag);
                    errors++;
                end
                if (out_w.saturated_flag !== want.sat) begin
                    $error("saturated_flag expected %0b actual %0b",
                           want.sat, out_w.saturated_flag);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no word moving.
    always @(posedge clk) begin
        if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)
            || (points_pending.size() == 0 && projections_due.size() == 0
                && !in_w.valid))
            quiet_cycles <= 0;
        else if (quiet_cycles >= StallLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrW'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_NORMAL_X:     plane.normal_x = v[15:0];
            REG_NORMAL_Y:     plane.normal_y = v[15:0];
            REG_NORMAL_Z:     plane.normal_z = v[15:0];
            REG_PLANE_OFFSET: plane.plane_offset = v;
            REG_DIR_X:        plane.dir_x = v[15:0];
            REG_DIR_Y:        plane.dir_y = v[15:0];
            REG_DIR_Z:        plane.dir_z = v[15:0];
            REG_ALONG_NORMAL: plane.along_normal = v[0];
            default: ;
        endcase
    endtask

    task automatic set_plane(input logic [15:0] nx, ny, nz, input logic [31:0] off,
                             input logic [15:0] dx, dy, dz, input logic an);
        write_reg(REG_NORMAL_X, {{16{nx[15]}}, nx});
        write_reg(REG_NORMAL_Y, {{16{ny[15]}}, ny});
        write_reg(REG_NORMAL_Z, {{16{nz[15]}}, nz});
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_DIR_X, {{16{dx[15]}}, dx});
        write_reg(REG_DIR_Y, {{16{dy[15]}}, dy});
        write_reg(REG_DIR_Z, {{16{dz[15]}}, dz});
        write_reg(REG_ALONG_NORMAL, {31'd0, an});
    endtask

    // Hold the sender until every result is back, then let the pipe empty.
    task automatic drain();
        while (points_pending.size() != 0 || in_w.valid || projections_due.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    task automatic queue_point(input logic [31:0] x, y, z);
        point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        points_pending.insert(points_pending.size(), pt);
    endtask

    initial begin
        logic [15:0] nx, ny, nz, dx, dy, dz;
        logic [31:0] off;
        plane = '0;
        plane.normal_z = 16'sd16384;
        plane.dir_z = 16'sd16384;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset plane (z = 0), coordinate extremes.
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        queue_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_point(32'h00010000, 32'hFFFF0000, 32'h00030000);
        drain();

        // Normal mode with extreme normal and offset: saturation.
        set_plane(16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFFFFFF, 16'h0, 16'h0, 16'h0, 1'b1);
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        queue_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
        drain();

        // Zero direction in direction mode, then direction in the plane: parallel.
        set_plane(16'h4000, 16'h0, 16'h0, 32'h80000000, 16'h0, 16'h0, 16'h0, 1'b0);
        queue_point(32'h00050000, 32'h1, 32'h80000000);
        drain();
        set_plane(16'h4000, 16'h0, 16'h0, 32'h00010000, 16'h0, 16'h7FFF, 16'h8000, 1'b0);
        queue_point(32'h7FFFFFFF, 32'h2, 32'h3);
        drain();

        // Zero normal in normal mode.
        set_plane(16'h0, 16'h0, 16'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 1'b1);
        queue_point(32'h1, 32'h2, 32'h3);
        drain();

        // Tiny denominator: huge delta, capped then clamped.
        set_plane(16'h0001, 16'h0, 16'h0, 32'h80000000, 16'h0001, 16'h7FFF, 16'h8000, 1'b0);
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        drain();

        // Random phases; one runs without any idling.
        for (int ph = 0; ph < 16; ph++) begin
            nx = rand_comp();
            ny = rand_comp();
            nz = rand_comp();
            if (nx == 0 && ny == 0 && nz == 0 && $urandom_range(0, 1)) nz = 16'h4000;
            off = ($urandom_range(0, 2) == 0) ? $urandom
                : 32'($signed($urandom_range(0, 32'hFFFFFF)) - 32'sh800000);
            if (ph % 5 == 4) begin
                // direction roughly in the plane, exactly so when nx and ny are even
                dx = {ny[15], ny[15:1]};
                dy = -{nx[15], nx[15:1]};
                dz = 16'h0;
                nz = 16'h0;
            end
            else begin
                dx = rand_comp();
                dy = rand_comp();
                dz = rand_comp();
            end
            set_plane(nx, ny, nz, off, dx, dy, dz, 1'($urandom_range(0, 1)));
            calm = (ph == 3);
            for (int k = 0; k < 100; k++)
                queue_point(rand_coord(), rand_coord(), rand_coord());
            drain();
            calm = 1'b0;
        end

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
